/* src/assert_macros.svh */
// Assertion macros shared by the frame filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication failed.");

`endif

/* src/rrf_pkg.sv */
// Package with types and codes of the receive frame filter and interrupt dispatcher.
package rrf_pkg;

   localparam int HEADER_WINDOW = 16;
   localparam int POS_W         = 5;

   typedef enum logic [1:0] {
      MODE_HDR_BYTE  = 2'd0,
      MODE_IRQ       = 2'd1,
      MODE_CCA_START = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_TX_DONE   = 3'd1,
      EV_RX_IND    = 3'd2,
      EV_RX_START  = 3'd3,
      EV_CRC_ERR   = 3'd4,
      EV_CCA_DONE  = 3'd5,
      EV_DROPPED   = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      FM_ACCEPT   = 2'd0,
      FM_PROMISC  = 2'd1,
      FM_ACK_ONLY = 2'd2
   } fmode_type;

   typedef enum logic [1:0] {
      REG_OWN_PAN     = 2'd0,
      REG_OWN_SHORT   = 2'd1,
      REG_OWN_LONG    = 2'd2,
      REG_FILTER_MODE = 2'd3
   } reg_idx_type;

   localparam logic [2:0]  FT_BEACON     = 3'd0;
   localparam logic [2:0]  FT_DATA       = 3'd1;
   localparam logic [2:0]  FT_ACK        = 3'd2;
   localparam logic [1:0]  AM_SHORT      = 2'd2;
   localparam logic [1:0]  AM_LONG       = 2'd3;
   localparam logic [15:0] BCAST_16      = 16'hFFFF;
   localparam logic [1:0]  FM_RESERVED   = 2'd3;

   localparam int IRQ_TXDONE  = 0;
   localparam int IRQ_RXDONE  = 1;
   localparam int IRQ_PREAMB  = 2;
   localparam int IRQ_SYNC    = 3;
   localparam int IRQ_HDROK   = 4;
   localparam int IRQ_HDRERR  = 5;
   localparam int IRQ_CRCERR  = 6;
   localparam int IRQ_CADDONE = 7;
   localparam int IRQ_CADDET  = 8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [9:0]  irq_mask;
   } req_item_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic       ack_needed;
      logic       cca_busy;
      logic       cca_finished;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  frame_kind;
      logic        ack_request;
      logic [1:0]  dest_mode;
      logic [15:0] dest_pan;
      logic [63:0] dest_addr;
   } hdr_type;

   typedef struct packed {
      logic [15:0] own_pan;
      logic [15:0] own_short;
      logic [63:0] own_long;
      logic [1:0]  filter_mode;
   } cfg_type;

endpackage

/* src/rrf_if.sv */
// Channel interfaces for the request and response transfers.
interface rrf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;
   logic       first_byte;
   logic [9:0] irq_mask;

   modport source (output valid, mode, data_byte, first_byte, irq_mask, input ready);
   modport sink   (input valid, mode, data_byte, first_byte, irq_mask, output ready);
endinterface

interface rrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       ack_needed;
   logic       cca_busy;
   logic       cca_finished;

   modport source (output valid, event_res, ack_needed, cca_busy, cca_finished, input ready);
   modport sink   (input valid, event_res, ack_needed, cca_busy, cca_finished, output ready);
endinterface

/* src/rrf_hdr_track.sv */
// Header byte tracker latching frame type, ack request and destination fields.
module rrf_hdr_track
   import rrf_pkg::*;
#(
   parameter int HDR_WINDOW = HEADER_WINDOW
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       first_byte,
   output hdr_type    hdr
);

   hdr_type           hdr_ff;
   hdr_type           hdr_in;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   hdr_type           base;
   logic [POS_W-1:0]  pos_cur;
   logic [2:0]        addr_byte;

   always_comb begin
      base      = first_byte ? '0 : hdr_ff;
      pos_cur   = first_byte ? '0 : pos_ff;
      addr_byte = 3'(pos_cur - POS_W'(5));
      hdr_in    = hdr_ff;
      pos_in    = pos_ff;
      if (take) begin
         hdr_in = base;
         if ({1'b0, pos_cur} < (POS_W + 1)'(HDR_WINDOW)) begin
            if (pos_cur == POS_W'(0)) begin
               hdr_in.frame_kind  = data_byte[2:0];
               hdr_in.ack_request = data_byte[5];
            end else if (pos_cur == POS_W'(1)) begin
               hdr_in.dest_mode = data_byte[3:2];
            end else if (pos_cur == POS_W'(3)) begin
               hdr_in.dest_pan[7:0] = data_byte;
            end else if (pos_cur == POS_W'(4)) begin
               hdr_in.dest_pan[15:8] = data_byte;
            end else if (pos_cur >= POS_W'(5) && pos_cur <= POS_W'(12)) begin
               hdr_in.dest_addr[{addr_byte, 3'b000} +: 8] = data_byte;
            end
         end
         pos_in = (pos_cur != '1) ? pos_cur + POS_W'(1) : pos_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
         pos_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
         pos_ff <= pos_in;
      end
   end

   assign hdr = hdr_ff;

endmodule

/* src/rrf_irq_dispatch.sv */
// Interrupt priority decoder, address filter and channel check flags.
module rrf_irq_dispatch
   import rrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [1:0]   mode,
   input  logic [9:0]   irq_mask,
   input  hdr_type      hdr,
   input  cfg_type      cfg,
   output rsp_item_type result
);

`include "assert_macros.svh"

   logic      cad_seen_ff;
   logic      cad_seen_in;
   logic      cad_done_ff;
   logic      cad_done_in;
   logic      match;
   logic      is_ack;
   logic      is_data;
   event_type ev;
   logic      ackn;

   always_comb begin
      if (hdr.frame_kind == FT_BEACON && cfg.own_pan == BCAST_16) begin
         match = 1'b1;
      end else if (hdr.dest_mode != AM_SHORT && hdr.dest_mode != AM_LONG) begin
         match = 1'b0;
      end else if (hdr.dest_pan != BCAST_16 && hdr.dest_pan != cfg.own_pan) begin
         match = 1'b0;
      end else if (hdr.dest_mode == AM_SHORT) begin
         match = (hdr.dest_addr[15:0] == cfg.own_short) || (hdr.dest_addr[15:0] == BCAST_16);
      end else begin
         match = (hdr.dest_addr == cfg.own_long);
      end
   end

   assign is_ack  = (hdr.frame_kind == FT_ACK);
   assign is_data = (hdr.frame_kind == FT_DATA);

   always_comb begin
      ev          = EV_NONE;
      ackn        = 1'b0;
      cad_seen_in = cad_seen_ff;
      cad_done_in = cad_done_ff;
      if (step && mode == MODE_CCA_START) begin
         cad_seen_in = 1'b0;
         cad_done_in = 1'b0;
      end
      priority if (irq_mask[IRQ_TXDONE]) begin
         ev = EV_TX_DONE;
      end else if (irq_mask[IRQ_RXDONE]) begin
         if (is_ack || (cfg.filter_mode != FM_ACK_ONLY && match)) begin
            ev   = EV_RX_IND;
            ackn = is_data && hdr.ack_request;
         end else if (cfg.filter_mode == FM_PROMISC) begin
            ev = EV_RX_IND;
         end else begin
            ev = EV_DROPPED;
         end
      end else if (irq_mask[IRQ_PREAMB] || irq_mask[IRQ_SYNC]) begin
         ev = EV_NONE;
      end else if (irq_mask[IRQ_HDROK]) begin
         ev = EV_RX_START;
      end else if (irq_mask[IRQ_HDRERR]) begin
         ev = EV_NONE;
      end else if (irq_mask[IRQ_CRCERR]) begin
         ev = EV_CRC_ERR;
      end else if (irq_mask[IRQ_CADDONE]) begin
         ev = EV_CCA_DONE;
         if (step && mode == MODE_IRQ) begin
            cad_done_in = 1'b1;
            if (irq_mask[IRQ_CADDET]) begin
               cad_seen_in = 1'b1;
            end
         end
      end else begin
         ev = EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cad_seen_ff <= 1'b0;
         cad_done_ff <= 1'b0;
      end else begin
         cad_seen_ff <= cad_seen_in;
         cad_done_ff <= cad_done_in;
      end
   end

   assign result.event_res    = ev;
   assign result.ack_needed   = ackn;
   assign result.cca_busy     = cad_seen_in;
   assign result.cca_finished = cad_done_in;

   `ASSERT_SAME(a_busy_needs_done, clock, reset, cad_seen_ff, cad_done_ff)
   `ASSERT_NEXT(a_cca_start_clears, clock, reset, step && mode == MODE_CCA_START,
                !cad_seen_ff && !cad_done_ff)

endmodule

/* src/radio_rx_frame_filter_irq_dispatch.sv */
// Top level of the receive frame filter and radio interrupt dispatcher.
//
// Items arrive on req_ch: header bytes (with a first-byte mark), interrupt
// masks and channel check starts. Each interrupt mask yields exactly one
// transfer on rsp_ch with the event code, the ack flag and the channel check
// flags; header bytes and channel check starts yield none.
// An accepted item is held in an input register; while it is held there the
// header latch, address filter and priority decoder act on it, and for an
// interrupt item the result is loaded into the output register, so a response
// is valid once its request has passed the input and the output register.
// One item is taken per cycle while rsp_ch keeps up.
// While the receiver stalls with a result pending, byte and channel check
// items still pass through; an interrupt item waits in the input register and
// req_ch.ready falls only once that register is occupied.
// The csr port writes own PAN, own short address, own long address and the
// filter mode; the user must write it only while the block is idle, as the block does not enforce this.
// Synchronous reset empties both registers, clears the latched header and the
// channel check flags, and loads the register reset values.
module radio_rx_frame_filter_irq_dispatch
   import rrf_pkg::*;
#(
   parameter int HDR_WINDOW = HEADER_WINDOW
)
(
   input  logic         clock,
   input  logic         reset,
   rrf_req_if.sink      req_ch,
   rrf_rsp_if.source    rsp_ch,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

`include "assert_macros.svh"

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         in_vld_ff;
   logic         in_vld_in;
   req_item_type in_item_ff;
   logic         out_vld_ff;
   logic         out_vld_in;
   rsp_item_type out_item_ff;
   logic         step;
   logic         is_irq;
   logic         req_take;
   hdr_type      hdr;
   rsp_item_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_OWN_PAN:     cfg_in.own_pan   = csr_wdata[15:0];
            REG_OWN_SHORT:   cfg_in.own_short = csr_wdata[15:0];
            REG_OWN_LONG:    cfg_in.own_long  = csr_wdata;
            REG_FILTER_MODE: begin
               if (csr_wdata[1:0] != FM_RESERVED) begin
                  cfg_in.filter_mode = csr_wdata[1:0];
               end
            end
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign is_irq   = (in_item_ff.mode == MODE_IRQ);
   assign step     = in_vld_ff && (!is_irq || !out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || step;
   assign req_take = req_ch.valid && req_ch.ready;

   assign in_vld_in  = req_take ? 1'b1 : (step ? 1'b0 : in_vld_ff);
   assign out_vld_in = (step && is_irq) ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_pan     <= BCAST_16;
         cfg_ff.own_short   <= '0;
         cfg_ff.own_long    <= '0;
         cfg_ff.filter_mode <= FM_ACCEPT;
         in_vld_ff          <= 1'b0;
         out_vld_ff         <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode       <= req_ch.mode;
         in_item_ff.data_byte  <= req_ch.data_byte;
         in_item_ff.first_byte <= req_ch.first_byte;
         in_item_ff.irq_mask   <= req_ch.irq_mask;
      end
      if (step && is_irq) begin
         out_item_ff <= result;
      end
   end

   rrf_hdr_track #(
      .HDR_WINDOW (HDR_WINDOW)
   ) u_hdr (
      .clock      (clock),
      .reset      (reset),
      .take       (step && in_item_ff.mode == MODE_HDR_BYTE),
      .data_byte  (in_item_ff.data_byte),
      .first_byte (in_item_ff.first_byte),
      .hdr        (hdr)
   );

   rrf_irq_dispatch u_dispatch (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .mode     (in_item_ff.mode),
      .irq_mask (in_item_ff.irq_mask),
      .hdr      (hdr),
      .cfg      (cfg_ff),
      .result   (result)
   );

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.event_res    = out_item_ff.event_res;
   assign rsp_ch.ack_needed   = out_item_ff.ack_needed;
   assign rsp_ch.cca_busy     = out_item_ff.cca_busy;
   assign rsp_ch.cca_finished = out_item_ff.cca_finished;

   `ASSERT_NEXT(a_irq_loads_output, clock, reset, step && is_irq, out_vld_ff)
   `ASSERT_SAME(a_ack_only_on_indicate, clock, reset, out_vld_ff && out_item_ff.ack_needed,
                out_item_ff.event_res == EV_RX_IND)
   `ASSERT_SAME(a_irq_waits_for_space, clock, reset, step && is_irq,
                !out_vld_ff || rsp_ch.ready)

endmodule
